[rtl/tcmr_pkg.sv]
package tcmr_pkg;

	typedef enum logic [1:0] {
		CMD_TICK    = 2'd0,
		CMD_SET_ONE = 2'd1,
		CMD_SET_ALL = 2'd2,
		CMD_STOP    = 2'd3
	} cmd_t;

	localparam int NUM_CH      = 3;
	localparam int SP_W        = 8;
	localparam int DUTY_W      = 7;
	localparam int SCALE_W     = 20;
	localparam int PROD_W      = DUTY_W + SCALE_W;
	// x / 100 is taken as (x * 5243) >> 19, exact for x up to 10000
	localparam int RECIP       = 5243;
	localparam int RECIP_SHIFT = 19;
	localparam int PCT_MAX     = 100;

	localparam logic signed [SP_W-1:0] SP_POS_LIM = 8'sd100;
	localparam logic signed [SP_W-1:0] SP_NEG_LIM = -8'sd100;

	typedef struct packed {
		logic tick;
		logic stop;
	} chan_ctrl_t;

	typedef struct packed {
		logic [SP_W-1:0]   ramp;
		logic              dir;
		logic [DUTY_W-1:0] duty;
	} chan_state_t;

endpackage

[rtl/tcmr_chan.sv]
module tcmr_chan
	import tcmr_pkg::*;
#(
	parameter int RAMP_STEP = 5
) (
	input  chan_ctrl_t             ctrl,
	input  logic signed [SP_W-1:0] setpoint,
	input  logic [SCALE_W-1:0]     scale,
	input  chan_state_t            cur,
	output chan_state_t            nxt
);

	localparam logic signed [9:0] STEP = 10'(RAMP_STEP);

	logic signed [SP_W-1:0] sp_neg;
	logic [DUTY_W-1:0]      sp_mag;
	logic [PROD_W-1:0]      prod;
	logic [DUTY_W-1:0]      tgt_mag;
	logic signed [SP_W-1:0] tgt_pos;
	logic signed [SP_W-1:0] target;
	logic signed [9:0]      tgt_w;
	logic signed [9:0]      cur_w;
	logic signed [9:0]      diff;
	logic signed [9:0]      ramp_w;
	logic signed [SP_W-1:0] ramp_n;
	logic signed [SP_W-1:0] ramp_neg;

	// scaled target magnitude, truncated toward zero
	assign sp_neg  = -setpoint;
	assign sp_mag  = setpoint[SP_W-1] ? sp_neg[DUTY_W-1:0] : setpoint[DUTY_W-1:0];
	assign prod    = PROD_W'(sp_mag) * PROD_W'(scale);
	assign tgt_mag = prod[RECIP_SHIFT +: DUTY_W];
	assign tgt_pos = signed'({1'b0, tgt_mag});
	assign target  = setpoint[SP_W-1] ? -tgt_pos : tgt_pos;

	assign tgt_w = 10'(target);
	assign cur_w = 10'(signed'(cur.ramp));
	assign diff  = tgt_w - cur_w;

	always_comb begin
		if (diff > STEP) begin
			ramp_w = cur_w + STEP;
		end else if (-diff > STEP) begin
			ramp_w = cur_w - STEP;
		end else begin
			ramp_w = tgt_w;
		end
	end

	assign ramp_n   = ramp_w[SP_W-1:0];
	assign ramp_neg = -ramp_n;

	always_comb begin
		nxt = cur;
		if (ctrl.tick) begin
			nxt.ramp = ramp_n;
			nxt.dir  = ~ramp_n[SP_W-1];
			nxt.duty = ramp_n[SP_W-1] ? ramp_neg[DUTY_W-1:0] : ramp_n[DUTY_W-1:0];
		end else if (ctrl.stop) begin
			// held pwm outputs stay until the next tick
			nxt.ramp = '0;
		end
	end

endmodule

[rtl/three_channel_motor_ramp.sv]
// Three-channel slew-limited motor drive (left, right, rear). Each request on the
// s_ side carries a command (tick, set one, set all, stop) and gives exactly one
// result on the m_ side: the held direction and duty of each motor, m_tuser set
// when that request was a tick, and the three stored setpoints. The block takes one
// request per clock cycle unless the m_ side stalls; a request passes the input
// register, then the result register, and the setpoint and ramp registers are
// updated once per request. A tick scales each setpoint by max_percent/100,
// then moves the ramped value by at most RAMP_STEP toward it. max_percent is written
// through cfg_wen/cfg_wdata (values above 100 saturate) and should only change
// while no request is in flight.
module three_channel_motor_ramp
	import tcmr_pkg::*;
#(
	parameter int RAMP_STEP = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [6:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// cmd[1:0], motor_number[3:2], single_value[11:4], value_left[19:12],
	// value_right[27:20], value_rear[35:28], zero[39:36]
	input  logic [39:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// dir_left[0], duty_left[7:1], dir_right[8], duty_right[15:9], dir_rear[16],
	// duty_rear[23:17], target_left[31:24], target_right[39:32], target_rear[47:40]
	output logic [47:0] m_tdata,
	// pwm_updated[0]
	output logic        m_tuser
);

	localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(PCT_MAX * RECIP);

	logic                   valid_s1;
	cmd_t                   cmd_s1;
	logic [1:0]             motor_number_s1;
	logic signed [SP_W-1:0] single_value_s1;
	logic signed [SP_W-1:0] values_s1 [NUM_CH];
	logic                   adv;

	logic [SCALE_W-1:0]     scale_q;
	logic [DUTY_W-1:0]      pct_sat;
	logic signed [SP_W-1:0] sp_q   [NUM_CH];
	logic signed [SP_W-1:0] sp_n   [NUM_CH];
	chan_state_t            chan_q [NUM_CH];
	chan_state_t            chan_n [NUM_CH];
	chan_ctrl_t             ctrl;

	logic                   out_valid_q;
	logic                   updated_q;
	chan_state_t            res_chan_q [NUM_CH];
	logic signed [SP_W-1:0] res_sp_q   [NUM_CH];

	function automatic logic signed [SP_W-1:0] sat100(input logic signed [SP_W-1:0] v);
		logic signed [SP_W-1:0] r;
		if (v > SP_POS_LIM) begin
			r = SP_POS_LIM;
		end else if (v < SP_NEG_LIM) begin
			r = SP_NEG_LIM;
		end else begin
			r = v;
		end
		return r;
	endfunction

	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1          <= cmd_t'(s_tdata[1:0]);
			motor_number_s1 <= s_tdata[3:2];
			single_value_s1 <= s_tdata[11:4];
			values_s1[0]    <= s_tdata[19:12];
			values_s1[1]    <= s_tdata[27:20];
			values_s1[2]    <= s_tdata[35:28];
		end
	end

	// scale kept as max_percent times the reciprocal of 100
	assign pct_sat = (cfg_wdata > DUTY_W'(PCT_MAX)) ? DUTY_W'(PCT_MAX) : cfg_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RST;
		end else if (cfg_wen) begin
			scale_q <= SCALE_W'(pct_sat * RECIP);
		end
	end

	assign ctrl.tick = (cmd_s1 == CMD_TICK);
	assign ctrl.stop = (cmd_s1 == CMD_STOP);

	always_comb begin
		for (int k = 0; k < NUM_CH; k++) begin
			sp_n[k] = sp_q[k];
			case (cmd_s1)
				CMD_SET_ONE: begin
					if (motor_number_s1 == 2'(k + 1)) begin
						sp_n[k] = sat100(single_value_s1);
					end
				end
				CMD_SET_ALL: sp_n[k] = sat100(values_s1[k]);
				CMD_STOP:    sp_n[k] = '0;
				default:     sp_n[k] = sp_q[k];
			endcase
		end
	end

	for (genvar g = 0; g < NUM_CH; g++) begin : g_chan
		tcmr_chan #(
			.RAMP_STEP(RAMP_STEP)
		) u_chan (
			.ctrl    (ctrl),
			.setpoint(sp_q[g]),
			.scale   (scale_q),
			.cur     (chan_q[g]),
			.nxt     (chan_n[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_CH; k++) begin
				sp_q[k]        <= '0;
				chan_q[k].ramp <= '0;
				chan_q[k].dir  <= 1'b1;
				chan_q[k].duty <= '0;
			end
		end else if (adv) begin
			for (int k = 0; k < NUM_CH; k++) begin
				sp_q[k]   <= sp_n[k];
				chan_q[k] <= chan_n[k];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			updated_q <= ctrl.tick;
			for (int k = 0; k < NUM_CH; k++) begin
				res_chan_q[k] <= chan_n[k];
				res_sp_q[k]   <= sp_n[k];
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = updated_q;
	assign m_tdata  = {res_sp_q[2], res_sp_q[1], res_sp_q[0],
		res_chan_q[2].duty, res_chan_q[2].dir,
		res_chan_q[1].duty, res_chan_q[1].dir,
		res_chan_q[0].duty, res_chan_q[0].dir};

endmodule

[rtl/tcmr_checker.sv]
module tcmr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tuser
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// duties never exceed full scale
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:1] <= 7'd100 && m_tdata[15:9] <= 7'd100 &&
			m_tdata[23:17] <= 7'd100)
		else $error("duty above 100");

	// setpoints stay saturated
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $signed(m_tdata[31:24]) >= -8'sd100 &&
			$signed(m_tdata[31:24]) <= 8'sd100 &&
			$signed(m_tdata[39:32]) >= -8'sd100 &&
			$signed(m_tdata[39:32]) <= 8'sd100 &&
			$signed(m_tdata[47:40]) >= -8'sd100 &&
			$signed(m_tdata[47:40]) <= 8'sd100)
		else $error("setpoint out of range");

	// reverse direction only with a non-zero magnitude
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] || m_tdata[7:1] != '0) &&
			(m_tdata[8] || m_tdata[15:9] != '0) &&
			(m_tdata[16] || m_tdata[23:17] != '0))
		else $error("reverse direction with zero duty");

endmodule

bind three_channel_motor_ramp tcmr_checker u_tcmr_checker (.*);
